/* src/sfc_pkg.sv */
`default_nettype none

package sfc_pkg;

  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [7:0]  SLAVE_ERR_BYTE = 8'hFF;
  localparam int unsigned QUEUE_DEPTH    = 2;

  // Result status codes
  localparam logic [1:0] STATUS_OK           = 2'd0;
  localparam logic [1:0] STATUS_SLAVE_ERR    = 2'd1;
  localparam logic [1:0] STATUS_CRC_MISMATCH = 2'd2;

  // Slot class decided at the front
  typedef enum logic [1:0] {
    SLOT_PAYLOAD,   // payload byte inside a frame
    SLOT_RESTART,   // payload byte after a lone trailer slot: new frame
    SLOT_TRL_HI,    // first trailer slot
    SLOT_TRL_LO     // second trailer slot, frame complete
  } slot_kind_e;

  typedef struct packed {
    slot_kind_e  kind;
    logic [7:0]  tx_byte;
    logic [7:0]  rx_byte;
    logic        check_rx;
  } slot_t;

  typedef struct packed {
    logic [7:0] wire_tx_byte;
    logic       frame_done;
    logic [1:0] status;
  } result_t;

  // CRC-16-CCITT, poly 0x1021, one byte, MSB first
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] x;
    x = crc[15:8] ^ b;
    x = x ^ {4'd0, x[7:4]};
    return {crc[7:0], 8'd0} ^ {x[3:0], 12'd0} ^ {3'd0, x, 5'd0} ^ {8'd0, x};
  endfunction

endpackage

`default_nettype wire

/* src/sfc_if.sv */
`default_nettype none

interface sfc_slot_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] tx_byte;
  logic [7:0] rx_byte;
  logic       check_rx;

  modport source (output valid, command, tx_byte, rx_byte, check_rx, input ready);
  modport sink   (input valid, command, tx_byte, rx_byte, check_rx, output ready);
endinterface

interface sfc_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] wire_tx_byte;
  logic       frame_done;
  logic [1:0] status;

  modport source (output valid, wire_tx_byte, frame_done, status, input ready);
  modport sink   (input valid, wire_tx_byte, frame_done, status, output ready);
endinterface

`default_nettype wire

/* src/sfc_front.sv */
`default_nettype none

module sfc_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  sfc_slot_if.sink           in_i,
  input  wire logic          full_i,
  output sfc_pkg::slot_t     push_data_o,
  output logic               push_o
);
  import sfc_pkg::*;

  logic trailer_half_q, trailer_half_d;
  logic accept;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign push_o     = accept;

  always_comb begin
    push_data_o.tx_byte  = in_i.tx_byte;
    push_data_o.rx_byte  = in_i.rx_byte;
    push_data_o.check_rx = in_i.check_rx;
    unique case ({in_i.command, trailer_half_q})
      2'b00:   push_data_o.kind = SLOT_PAYLOAD;
      2'b01:   push_data_o.kind = SLOT_RESTART;
      2'b10:   push_data_o.kind = SLOT_TRL_HI;
      default: push_data_o.kind = SLOT_TRL_LO;
    endcase
    trailer_half_d = trailer_half_q;
    if (accept) begin
      trailer_half_d = in_i.command && !trailer_half_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trailer_half_q <= 1'b0;
    end else begin
      trailer_half_q <= trailer_half_d;
    end
  end

`ifndef SYNTHESIS
  a_half_after_hi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && push_data_o.kind == SLOT_TRL_HI |=> trailer_half_q)
    else $error("trailer half flag not set after first trailer slot");
`endif

endmodule

`default_nettype wire

/* src/sfc_queue.sv */
`default_nettype none

module sfc_queue #(
  parameter int unsigned Depth = sfc_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire sfc_pkg::slot_t  push_data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output sfc_pkg::slot_t       pop_data_o,
  output logic                 empty_o
);
  import sfc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  slot_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o     = (count_q == CntW'(Depth));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_next(rd_ptr_q);
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> !empty_o)
    else $error("queue empty after push");
`endif

endmodule

`default_nettype wire

/* src/sfc_back.sv */
`default_nettype none

module sfc_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            empty_i,
  input  wire sfc_pkg::slot_t  slot_i,
  output logic                 pop_o,
  sfc_result_if.source         out_o
);
  import sfc_pkg::*;

  logic [15:0] tx_crc_q, tx_crc_d;
  logic [15:0] rx_crc_q, rx_crc_d;
  logic        at_start_q, at_start_d;
  logic        err_q, err_d;
  logic [7:0]  rx_crc_high_q, rx_crc_high_d;
  logic        out_valid_q, out_valid_d;
  result_t     out_q, out_d;

  logic [15:0] tx_base, rx_base;
  logic        start_base, err_base;

  assign pop_o = !empty_i && (!out_valid_q || out_o.ready);

  always_comb begin
    tx_crc_d      = tx_crc_q;
    rx_crc_d      = rx_crc_q;
    at_start_d    = at_start_q;
    err_d         = err_q;
    rx_crc_high_d = rx_crc_high_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q && !out_o.ready;

    // A restart drops the half frame before the slot is folded in
    tx_base    = (slot_i.kind == SLOT_RESTART) ? CRC_INIT : tx_crc_q;
    rx_base    = (slot_i.kind == SLOT_RESTART) ? CRC_INIT : rx_crc_q;
    start_base = (slot_i.kind == SLOT_RESTART) ? 1'b1 : at_start_q;
    err_base   = (slot_i.kind == SLOT_RESTART) ? 1'b0 : err_q;

    if (pop_o) begin
      out_valid_d      = 1'b1;
      out_d.frame_done = 1'b0;
      out_d.status     = STATUS_OK;
      unique case (slot_i.kind)
        SLOT_PAYLOAD, SLOT_RESTART: begin
          out_d.wire_tx_byte = slot_i.tx_byte;
          tx_crc_d   = crc_fold(tx_base, slot_i.tx_byte);
          rx_crc_d   = crc_fold(rx_base, slot_i.rx_byte);
          at_start_d = 1'b0;
          err_d      = start_base ? (slot_i.rx_byte == SLAVE_ERR_BYTE) : err_base;
        end
        SLOT_TRL_HI: begin
          out_d.wire_tx_byte = tx_crc_q[15:8];
          rx_crc_high_d = slot_i.rx_byte;
          at_start_d    = 1'b0;
          err_d         = at_start_q ? (slot_i.rx_byte == SLAVE_ERR_BYTE) : err_q;
        end
        default: begin
          out_d.wire_tx_byte = tx_crc_q[7:0];
          out_d.frame_done   = 1'b1;
          if (slot_i.check_rx) begin
            priority if (err_q) begin
              out_d.status = STATUS_SLAVE_ERR;
            end else if ({rx_crc_high_q, slot_i.rx_byte} != rx_crc_q) begin
              out_d.status = STATUS_CRC_MISMATCH;
            end else begin
              out_d.status = STATUS_OK;
            end
          end
          tx_crc_d   = CRC_INIT;
          rx_crc_d   = CRC_INIT;
          at_start_d = 1'b1;
          err_d      = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_crc_q      <= CRC_INIT;
      rx_crc_q      <= CRC_INIT;
      at_start_q    <= 1'b1;
      err_q         <= 1'b0;
      rx_crc_high_q <= 8'd0;
      out_valid_q   <= 1'b0;
    end else begin
      tx_crc_q      <= tx_crc_d;
      rx_crc_q      <= rx_crc_d;
      at_start_q    <= at_start_d;
      err_q         <= err_d;
      rx_crc_high_q <= rx_crc_high_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.wire_tx_byte = out_q.wire_tx_byte;
  assign out_o.frame_done   = out_q.frame_done;
  assign out_o.status       = out_q.status;

`ifndef SYNTHESIS
  a_status_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status != STATUS_OK |-> out_q.frame_done)
    else $error("status reported outside frame completion");
  a_reinit_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && slot_i.kind == SLOT_TRL_LO |=> tx_crc_q == CRC_INIT && at_start_q && !err_q)
    else $error("frame state not reinitialized after completion");
`endif

endmodule

`default_nettype wire

/* src/spi_frame_crc16_append_check.sv */
`default_nettype none

// Channel  Dir  Payload                                   Handshake
// in_i     in   command, tx_byte, rx_byte, check_rx       valid/ready
// out_o    out  wire_tx_byte, frame_done, status          valid/ready
//
// One result item per input item, one item per cycle sustained while out_o is ready.
// Each item is registered in the slot queue and then in the output register.
// The byte-wise CRC folds for both directions run combinationally in the back end.
// Reset (rst_ni low, asynchronous) empties the queue and output register and sets
// both CRCs to 0xFFFF with the frame start flag raised.
// A stall on out_o fills the queue; in_i.ready drops only when the queue is full.
module spi_frame_crc16_append_check #(
  parameter int unsigned QueueDepth = sfc_pkg::QUEUE_DEPTH
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  sfc_slot_if.sink       in_i,
  sfc_result_if.source   out_o
);
  import sfc_pkg::*;

  // Front to queue
  slot_t push_data;
  logic  push;
  logic  full;

  // Queue to back end
  slot_t pop_data;
  logic  pop;
  logic  empty;

  // Classify each slot: payload, restart after a lone trailer, or trailer half
  sfc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .full_i      (full),
    .push_data_o (push_data),
    .push_o      (push)
  );

  // Decouple acceptance from the result stall
  sfc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  // Fold CRCs, drive trailer bytes, check the frame on completion
  sfc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .slot_i  (pop_data),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

/* dv/sfc_crc_sb_pkg.sv */
package sfc_crc_sb_pkg;

  import sfc_pkg::*;

  // Slot commands as seen on in_i.command
  localparam bit CMD_PAYLOAD = 1'b0;
  localparam bit CMD_TRAILER = 1'b1;

  localparam logic [15:0] CCITT_POLY = 16'h1021;

  // Bit-serial CRC-16-CCITT update, MSB first
  function automatic logic [15:0] fold_crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CCITT_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  class frame_crc_tracker;
    logic [15:0] tx_crc;
    logic [15:0] rx_crc;
    bit          at_start;
    bit          first_rx_err;
    bit          trailer_half;
    logic [7:0]  rx_crc_hi;
    result_t     results_due[$];
    int unsigned mismatches;

    function new();
      restart_frame();
      rx_crc_hi  = '0;
      mismatches = 0;
    endfunction

    function void restart_frame();
      tx_crc       = CRC_INIT;
      rx_crc       = CRC_INIT;
      at_start     = 1'b1;
      first_rx_err = 1'b0;
      trailer_half = 1'b0;
    endfunction

    function void note_first_rx(input logic [7:0] rx);
      if (at_start) begin
        first_rx_err = (rx == SLAVE_ERR_BYTE);
        at_start     = 1'b0;
      end
    endfunction

    // Work out the result of one accepted slot and queue it
    function void note_slot(input bit cmd, input logic [7:0] tx, input logic [7:0] rx,
                            input bit chk);
      result_t r;
      r = '0;
      if (cmd == CMD_PAYLOAD) begin
        if (trailer_half) restart_frame();
        note_first_rx(rx);
        r.wire_tx_byte = tx;
        tx_crc = fold_crc_byte(tx_crc, tx);
        rx_crc = fold_crc_byte(rx_crc, rx);
      end else if (!trailer_half) begin
        note_first_rx(rx);
        r.wire_tx_byte = tx_crc[15:8];
        rx_crc_hi      = rx;
        trailer_half   = 1'b1;
      end else begin
        r.wire_tx_byte = tx_crc[7:0];
        r.frame_done   = 1'b1;
        r.status       = STATUS_OK;
        if (chk) begin
          if (first_rx_err) r.status = STATUS_SLAVE_ERR;
          else if ({rx_crc_hi, rx} != rx_crc) r.status = STATUS_CRC_MISMATCH;
        end
        restart_frame();
      end
      results_due.push_back(r);
    endfunction

    function void check_result(input logic [7:0] wire_byte, input logic done,
                               input logic [1:0] st);
      result_t want;
      if (results_due.size() == 0) begin
        $error("unexpected result item: wire_tx_byte=%h frame_done=%b status=%0d",
               wire_byte, done, st);
        mismatches++;
        return;
      end
      want = results_due.pop_front();
      if (wire_byte !== want.wire_tx_byte) begin
        $error("wire_tx_byte: expected %h, actual %h", want.wire_tx_byte, wire_byte);
        mismatches++;
      end
      if (done !== want.frame_done) begin
        $error("frame_done: expected %b, actual %b", want.frame_done, done);
        mismatches++;
      end
      if (st !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, st);
        mismatches++;
      end
    endfunction
  endclass

endpackage

/* dv/spi_frame_crc16_append_check_tb.sv */
module spi_frame_crc16_append_check_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import sfc_pkg::*;
  import sfc_crc_sb_pkg::*;

  localparam int unsigned CLK_PERIOD   = 8;
  localparam int unsigned RESET_CYCLES = 9;
  localparam int unsigned TOTAL_ITEMS  = 600;
  localparam int unsigned CALM_FROM    = 520;  // no idling on either side past this item
  localparam int unsigned LONG_HOLD    = 60;   // receiver hold-off that fills the block
  localparam int unsigned DRAIN_CYCLES = 8;

  logic clk = 1'b0;
  logic rst_n;

  sfc_slot_if   slot_if ();
  sfc_result_if res_if ();

  spi_frame_crc16_append_check uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (slot_if),
    .out_o  (res_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  frame_crc_tracker sb;
  int unsigned      items_sent;
  bit               no_gaps;
  bit               hold_off_req;

  // Offer one slot and hold it until the block takes it. Called right after a
  // rising edge; returns right after the edge that accepted the item, with
  // valid still high so a back-to-back item needs no second assignment.
  task automatic send_slot(input bit cmd, input logic [7:0] tx, input logic [7:0] rx,
                           input bit chk);
    int unsigned gap;
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      slot_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    slot_if.valid    <= 1'b1;
    slot_if.command  <= cmd;
    slot_if.tx_byte  <= tx;
    slot_if.rx_byte  <= rx;
    slot_if.check_rx <= chk;
    // Sample ready as it stood before the edge
    @(posedge clk);
    while (!slot_if.ready) @(posedge clk);
    sb.note_slot(cmd, tx, rx, chk);
    items_sent++;
  endtask

  // Send a frame of n payload slots and its trailer. A good trailer carries
  // the CRC of the received payload; a bad one has it corrupted. With
  // complete low, stop after the first trailer slot so the next payload
  // slot restarts the frame.
  task automatic send_frame(input int unsigned n, input bit chk, input bit good_crc,
                            input bit first_ff, input bit complete);
    logic [15:0] rx_sum;
    logic [15:0] trailer;
    logic [7:0]  rx;
    rx_sum = CRC_INIT;
    for (int unsigned i = 0; i < n; i++) begin
      rx = 8'($urandom);
      if (i == 0) begin
        // Keep the slave error byte for frames that ask for it
        if (first_ff) rx = SLAVE_ERR_BYTE;
        else if (rx == SLAVE_ERR_BYTE) rx = 8'h00;
      end
      send_slot(CMD_PAYLOAD, 8'($urandom), rx, 1'($urandom));
      rx_sum = fold_crc_byte(rx_sum, rx);
    end
    trailer = good_crc ? rx_sum : rx_sum ^ 16'($urandom_range(1, 16'hFFFF));
    // Empty frame: the trailer high byte is the first received byte
    if (n == 0 && first_ff) trailer[15:8] = SLAVE_ERR_BYTE;
    send_slot(CMD_TRAILER, 8'($urandom), trailer[15:8], 1'($urandom));
    if (complete) send_slot(CMD_TRAILER, 8'($urandom), trailer[7:0], chk);
  endtask

  // Check every result item taken by the receiver
  always @(posedge clk) begin
    if (rst_n === 1'b1 && res_if.valid && res_if.ready) begin
      sb.check_result(res_if.wire_tx_byte, res_if.frame_done, res_if.status);
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none late in the run
  initial begin
    int unsigned hold;
    hold = 0;
    res_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        res_if.ready <= 1'b0;
        hold--;
      end else if (!no_gaps && $urandom_range(0, 7) == 0) begin
        // First stalled cycle is this one; the rest of the burst follows
        res_if.ready <= 1'b0;
        hold = $urandom_range(0, 13);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Main sequence
  initial begin
    int unsigned pick;
    int unsigned len;
    sb = new();
    items_sent   = 0;
    no_gaps      = 1'b0;
    hold_off_req = 1'b0;
    rst_n            <= 1'b0;
    slot_if.valid    <= 1'b0;
    slot_if.command  <= CMD_PAYLOAD;
    slot_if.tx_byte  <= '0;
    slot_if.rx_byte  <= '0;
    slot_if.check_rx <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extremes of the bytes; first received byte is the slave error byte and
    // the CRC is also wrong, so error priority must win
    send_slot(CMD_PAYLOAD, 8'h00, 8'hFF, 1'b0);
    send_slot(CMD_PAYLOAD, 8'hFF, 8'h00, 1'b1);
    send_slot(CMD_TRAILER, 8'hFF, 8'h00, 1'b1);
    send_slot(CMD_TRAILER, 8'h00, 8'hFF, 1'b1);
    // Clean checked frame, then a CRC mismatch, then an unchecked bad frame
    send_frame(3, 1'b1, 1'b1, 1'b0, 1'b1);
    send_frame(2, 1'b1, 1'b0, 1'b0, 1'b1);
    send_frame(1, 1'b0, 1'b0, 1'b0, 1'b1);
    // Empty payload: trailer high byte is the slave error byte, then a plain mismatch
    send_frame(0, 1'b1, 1'b0, 1'b1, 1'b1);
    send_slot(CMD_TRAILER, 8'hFF, 8'h12, 1'b1);
    send_slot(CMD_TRAILER, 8'h00, 8'h34, 1'b1);
    // Drop a frame after one trailer slot; the next payload slot starts over
    send_frame(2, 1'b1, 1'b1, 1'b0, 1'b0);
    send_frame(1, 1'b1, 1'b1, 1'b0, 1'b1);

    // Random part: mostly well-formed frames, some broken ones and loose slots.
    // Ask the receiver for a long hold-off right away while items keep coming.
    hold_off_req = 1'b1;
    while (items_sent < TOTAL_ITEMS) begin
      no_gaps = (items_sent >= CALM_FROM);
      pick = $urandom_range(0, 99);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 32) : $urandom_range(0, 6);
      if (pick < 70) begin
        send_frame(len, $urandom_range(0, 4) != 0, $urandom_range(0, 3) != 0,
                   $urandom_range(0, 9) == 0, 1'b1);
      end else if (pick < 85) begin
        send_frame(len, 1'($urandom), 1'($urandom), $urandom_range(0, 9) == 0, 1'b0);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_slot(1'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
        end
      end
    end
    slot_if.valid <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    while (sb.results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("[spi_frame_crc16_append_check] OK");
    end else begin
      $display("[spi_frame_crc16_append_check] ERROR");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run
  initial begin
    #2_000_000;
    $display("[spi_frame_crc16_append_check] ERROR");
    $finish;
  end

endmodule

/* filelist.f */
src/sfc_pkg.sv
src/sfc_if.sv
src/sfc_front.sv
src/sfc_queue.sv
src/sfc_back.sv
src/spi_frame_crc16_append_check.sv
dv/sfc_crc_sb_pkg.sv
dv/spi_frame_crc16_append_check_tb.sv
